/* hw/rtl/planar_geometric_predicates_top_macros.svh */
// Assertion macros shared by the planar geometric predicates checker.
`ifndef PLANAR_GEOMETRIC_PREDICATES_TOP_MACROS_SVH
`define PLANAR_GEOMETRIC_PREDICATES_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PGP_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PGP_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("assertion failed");

// Next-cycle implication that also holds while reset is applied.
`define PGP_ASSERT_ALWAYS(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) (ant) |=> (con)) \
        else $error("assertion failed");

`endif

/* hw/rtl/pgp_pkg.sv */
// Package with the constants and codes of the planar geometric predicates block.
`timescale 1ns / 1ps
package pgp_pkg;
    localparam int COORD_WIDTH  = 16;
    localparam int VERTEX_DEPTH = 256;
    localparam int INDEX_WIDTH  = $clog2(VERTEX_DEPTH);
    // Coordinate differences, lifted terms, cofactors and the accumulator.
    localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
    localparam int LIFT_WIDTH   = 2 * DIFF_WIDTH + 1;
    localparam int COF_WIDTH    = LIFT_WIDTH + DIFF_WIDTH + 1;
    localparam int ACC_WIDTH    = COF_WIDTH + DIFF_WIDTH + 2;
    localparam int BIT_WIDTH    = $clog2(DIFF_WIDTH);

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_LINE   = 2'd1,
        ACT_TRI    = 2'd2,
        ACT_CIRCLE = 2'd3
    } t_action;

    localparam logic [1:0] SIDE_ZERO = 2'b00;
    localparam logic [1:0] SIDE_POS  = 2'b01;
    localparam logic [1:0] SIDE_NEG  = 2'b11;
endpackage

/* hw/rtl/planar_geometric_predicates_top.sv */
// Top level of the planar geometric predicates block: vertex table and serial sign engine.
//
// Usage: one input channel (i_valid / o_ready) carries items. A write item
// (action 0) stores a vertex in the 256-entry table and returns side 0. A
// query item reads its vertices from the table, and its point too when
// i_use_stored_point is set, then computes an exact sign with a bit-serial
// multiply-accumulate unit, and returns one result item on the output
// channel (o_valid / i_ready). A query first reads up to four table entries
// through the single read port, then runs each multiply-accumulate step as
// a load, a pass over the 17 multiplier bits, and a post. A line test takes
// 2 steps, a triangle test 2 to 6 steps, a circumcircle test 15 steps. One
// item is in work at a time; the serial multiplier sets the throughput.
// Reset (synchronous, active low) empties the output register and returns
// to idle; the vertex table is not cleared, and entries must be written
// before they are read.
// When the receiver stalls, the finished result waits in the output
// register; the block still accepts a new item and works on it, holding
// its result back until the output register is free.
`timescale 1ns / 1ps
module planar_geometric_predicates_top
    import pgp_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_action,
    input  logic [INDEX_WIDTH-1:0]        i_entry_index,
    input  logic                          i_use_stored_point,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic [INDEX_WIDTH-1:0]        i_first_vertex,
    input  logic [INDEX_WIDTH-1:0]        i_second_vertex,
    input  logic [INDEX_WIDTH-1:0]        i_third_vertex,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [1:0]             o_side
);

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_LOAD, S_MUL, S_POST, S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic [1:0] r_out_side;

    // Item registers.
    logic [1:0]                    r_action;
    logic [INDEX_WIDTH-1:0]        r_entry;
    logic                          r_stored;
    logic [INDEX_WIDTH-1:0]        r_vidx [3];
    logic signed [COORD_WIDTH-1:0] r_px, r_py;
    logic signed [COORD_WIDTH-1:0] r_vx [3];
    logic signed [COORD_WIDTH-1:0] r_vy [3];

    // Sequencer and serial multiplier.
    logic [2:0]                    r_cnt;
    logic [3:0]                    r_op;
    logic [BIT_WIDTH-1:0]          r_bit;
    logic signed [ACC_WIDTH-1:0]   r_ma;
    logic [DIFF_WIDTH-1:0]         r_mb;
    logic                          r_neg;
    logic signed [ACC_WIDTH-1:0]   r_acc;
    logic signed [ACC_WIDTH-1:0]   n_acc;
    logic signed [LIFT_WIDTH-1:0]  r_z [3];
    logic signed [COF_WIDTH-1:0]   r_c [3];
    logic                          r_nz;
    logic [1:0]                    r_side;

    // Vertex table: x in the low half, y in the high half.
    logic [2*COORD_WIDTH-1:0] r_mem [VERTEX_DEPTH];
    logic [2*COORD_WIDTH-1:0] r_rd;
    logic [INDEX_WIDTH-1:0]   rd_addr;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_side  = r_out_side;

    always_comb begin
        case (r_cnt)
            3'd1:    rd_addr = r_vidx[0];
            3'd2:    rd_addr = r_vidx[1];
            3'd3:    rd_addr = r_vidx[2];
            default: rd_addr = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && (i_action == ACT_WRITE)) begin
            r_mem[i_entry_index] <= {i_point_y, i_point_x};
        end
        r_rd <= r_mem[rd_addr];
    end

    // Differences relative to the query point, used by the circle test.
    logic signed [DIFF_WIDTH-1:0] dx [3];
    logic signed [DIFF_WIDTH-1:0] dy [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dx[k] = DIFF_WIDTH'(r_vx[k]) - DIFF_WIDTH'(r_px);
            dy[k] = DIFF_WIDTH'(r_vy[k]) - DIFF_WIDTH'(r_py);
        end
    end

    // Operand decode for the current multiply-accumulate step.
    logic signed [ACC_WIDTH-1:0]  op_a;
    logic signed [DIFF_WIDTH-1:0] op_b;
    logic                         op_neg;
    logic                         op_clr;
    logic [1:0]                   pair;
    logic [1:0]                   vi, vj;

    always_comb begin
        pair   = (r_action == ACT_LINE) ? 2'd2 : r_op[2:1];
        vi     = (pair == 2'd0) ? 2'd1 : 2'd0;
        vj     = (pair == 2'd2) ? 2'd1 : 2'd2;
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        op_clr = 1'b0;
        if (r_action == ACT_CIRCLE) begin
            case (r_op)
                4'd0:  begin op_a = ACC_WIDTH'(dx[0]); op_b = dx[0]; op_clr = 1'b1; end
                4'd1:  begin op_a = ACC_WIDTH'(dy[0]); op_b = dy[0]; end
                4'd2:  begin op_a = ACC_WIDTH'(dx[1]); op_b = dx[1]; op_clr = 1'b1; end
                4'd3:  begin op_a = ACC_WIDTH'(dy[1]); op_b = dy[1]; end
                4'd4:  begin op_a = ACC_WIDTH'(dx[2]); op_b = dx[2]; op_clr = 1'b1; end
                4'd5:  begin op_a = ACC_WIDTH'(dy[2]); op_b = dy[2]; end
                4'd6:  begin op_a = ACC_WIDTH'(r_z[2]); op_b = dy[1]; op_clr = 1'b1; end
                4'd7:  begin op_a = ACC_WIDTH'(r_z[1]); op_b = dy[2]; op_neg = 1'b1; end
                4'd8:  begin op_a = ACC_WIDTH'(r_z[0]); op_b = dy[2]; op_clr = 1'b1; end
                4'd9:  begin op_a = ACC_WIDTH'(r_z[2]); op_b = dy[0]; op_neg = 1'b1; end
                4'd10: begin op_a = ACC_WIDTH'(r_z[1]); op_b = dy[0]; op_clr = 1'b1; end
                4'd11: begin op_a = ACC_WIDTH'(r_z[0]); op_b = dy[1]; op_neg = 1'b1; end
                4'd12: begin op_a = ACC_WIDTH'(r_c[0]); op_b = dx[0]; op_clr = 1'b1; end
                4'd13: begin op_a = ACC_WIDTH'(r_c[1]); op_b = dx[1]; end
                4'd14: begin op_a = ACC_WIDTH'(r_c[2]); op_b = dx[2]; end
                default: begin op_a = '0; op_b = '0; end
            endcase
        end else if (!r_op[0]) begin
            // First product of a line determinant: (p - v_i) x times (v_j - v_i) y.
            op_a   = ACC_WIDTH'(DIFF_WIDTH'(r_px) - DIFF_WIDTH'(r_vx[vi]));
            op_b   = DIFF_WIDTH'(r_vy[vj]) - DIFF_WIDTH'(r_vy[vi]);
            op_clr = 1'b1;
        end else begin
            op_a   = ACC_WIDTH'(DIFF_WIDTH'(r_vx[vj]) - DIFF_WIDTH'(r_vx[vi]));
            op_b   = DIFF_WIDTH'(r_py) - DIFF_WIDTH'(r_vy[vi]);
            op_neg = 1'b1;
        end
    end

    // The multiplier's top bit carries negative weight.
    logic mul_sub;
    assign mul_sub = r_neg ^ (r_bit == BIT_WIDTH'(DIFF_WIDTH - 1));
    assign n_acc   = mul_sub ? (r_acc - r_ma) : (r_acc + r_ma);

    logic acc_neg, acc_zero, acc_pos;
    assign acc_neg  = r_acc[ACC_WIDTH-1];
    assign acc_zero = (r_acc == '0);
    assign acc_pos  = !acc_neg && !acc_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_action  <= i_action;
                        r_entry   <= i_entry_index;
                        r_stored  <= i_use_stored_point;
                        r_px      <= i_point_x;
                        r_py      <= i_point_y;
                        r_vidx[0] <= i_first_vertex;
                        r_vidx[1] <= i_second_vertex;
                        r_vidx[2] <= i_third_vertex;
                        r_cnt     <= '0;
                        if (i_action == ACT_WRITE) begin
                            r_side  <= SIDE_ZERO;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    r_cnt <= r_cnt + 3'd1;
                    case (r_cnt)
                        3'd1: begin
                            if (r_stored) begin
                                r_px <= r_rd[COORD_WIDTH-1:0];
                                r_py <= r_rd[2*COORD_WIDTH-1:COORD_WIDTH];
                            end
                        end
                        3'd2: begin
                            r_vx[0] <= r_rd[COORD_WIDTH-1:0];
                            r_vy[0] <= r_rd[2*COORD_WIDTH-1:COORD_WIDTH];
                        end
                        3'd3: begin
                            r_vx[1] <= r_rd[COORD_WIDTH-1:0];
                            r_vy[1] <= r_rd[2*COORD_WIDTH-1:COORD_WIDTH];
                        end
                        3'd4: begin
                            r_vx[2] <= r_rd[COORD_WIDTH-1:0];
                            r_vy[2] <= r_rd[2*COORD_WIDTH-1:COORD_WIDTH];
                            r_op    <= '0;
                            r_nz    <= 1'b1;
                            r_state <= S_LOAD;
                        end
                        default: begin
                        end
                    endcase
                end
                S_LOAD: begin
                    r_ma  <= op_a;
                    r_mb  <= op_b;
                    r_neg <= op_neg;
                    r_bit <= '0;
                    if (op_clr) begin
                        r_acc <= '0;
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_mb[0]) begin
                        r_acc <= n_acc;
                    end
                    r_ma  <= r_ma <<< 1;
                    r_mb  <= r_mb >> 1;
                    r_bit <= r_bit + BIT_WIDTH'(1);
                    if (r_bit == BIT_WIDTH'(DIFF_WIDTH - 1)) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    r_op    <= r_op + 4'd1;
                    r_state <= S_LOAD;
                    case (r_action)
                        ACT_LINE: begin
                            if (r_op[0]) begin
                                r_side  <= acc_pos ? SIDE_POS : (acc_neg ? SIDE_NEG : SIDE_ZERO);
                                r_state <= S_DONE;
                            end
                        end
                        ACT_TRI: begin
                            if (r_op[0]) begin
                                if (acc_zero) begin
                                    r_nz <= 1'b0;
                                end
                                case (r_op[2:1])
                                    2'd0: begin
                                        if (acc_pos) begin
                                            r_side  <= SIDE_POS;
                                            r_state <= S_DONE;
                                        end
                                    end
                                    2'd1: begin
                                        if (acc_neg) begin
                                            r_side  <= SIDE_POS;
                                            r_state <= S_DONE;
                                        end
                                    end
                                    default: begin
                                        if (acc_pos) begin
                                            r_side <= SIDE_POS;
                                        end else begin
                                            r_side <= (r_nz && !acc_zero) ? SIDE_NEG : SIDE_ZERO;
                                        end
                                        r_state <= S_DONE;
                                    end
                                endcase
                            end
                        end
                        default: begin
                            case (r_op)
                                4'd1:  r_z[0] <= r_acc[LIFT_WIDTH-1:0];
                                4'd3:  r_z[1] <= r_acc[LIFT_WIDTH-1:0];
                                4'd5:  r_z[2] <= r_acc[LIFT_WIDTH-1:0];
                                4'd7:  r_c[0] <= r_acc[COF_WIDTH-1:0];
                                4'd9:  r_c[1] <= r_acc[COF_WIDTH-1:0];
                                4'd11: r_c[2] <= r_acc[COF_WIDTH-1:0];
                                4'd14: begin
                                    // Negative lifted determinant means outside.
                                    r_side  <= acc_neg ? SIDE_POS : (acc_zero ? SIDE_ZERO : SIDE_NEG);
                                    r_state <= S_DONE;
                                end
                                default: begin
                                end
                            endcase
                        end
                    endcase
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_side  <= r_side;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/pgp_checker.sv */
// Port-level checker for the planar geometric predicates block, with its bind.
`timescale 1ns / 1ps
`include "planar_geometric_predicates_top_macros.svh"
module pgp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic signed [1:0] o_side
);

    // A stalled result holds its value.
    `PGP_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_side))
    // The sign code 2'b10 is never produced.
    `PGP_ASSERT_NOW(a_side_code, o_valid, o_side != 2'b10)
    // After an item is taken, the block is not ready in the next cycle.
    `PGP_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)
    // Reset empties the output register.
    `PGP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n, !o_valid)

endmodule

bind planar_geometric_predicates_top pgp_checker u_pgp_checker (.*);
